>>> rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// shared widths, codes and types of the elevator request controller
// ----------------------------------------------------------------------------
package erc_pkg;

   localparam int FLOOR_COUNT = 16;
   localparam int FLOOR_W     = 5;
   localparam int FLOOR_IDX_W = $clog2(FLOOR_COUNT);
   localparam int CMD_W       = 3;
   localparam int ACT_W       = 3;
   localparam int MODE_W      = 3;
   localparam int TICK_W      = 16;

   localparam logic [TICK_W-1:0] WAIT_RESET = TICK_W'(2000);
   localparam logic [TICK_W-1:0] TICK_MAX   = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_BUTTON  = 3'd0,
      CMD_OPEN    = 3'd1,
      CMD_OPENED  = 3'd2,
      CMD_DECIDE  = 3'd3,
      CMD_STOPPED = 3'd4,
      CMD_TICK    = 3'd5
   } cmd_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_OPEN    = 3'd0,
      ACT_CLOSE   = 3'd1,
      ACT_MOVE    = 3'd2,
      ACT_STOP    = 3'd3,
      ACT_RELEASE = 3'd4
   } act_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE     = 3'd0,
      MODE_OPENING  = 3'd1,
      MODE_WAITING  = 3'd2,
      MODE_CLOSING  = 3'd3,
      MODE_DECIDING = 3'd4,
      MODE_MOVING   = 3'd5
   } mode_type;

   typedef struct packed {
      logic               start;
      logic [FLOOR_W-1:0] cabin;
      logic               down;
   } scan_ctl_type;

   typedef struct packed {
      logic               done;
      logic [FLOOR_W-1:0] target;
   } scan_res_type;

endpackage

>>> rtl/erc_channels.sv
// ----------------------------------------------------------------------------
// erc channels
// request and response channel interfaces, valid/ready handshake
// ----------------------------------------------------------------------------
interface erc_req_if;
   logic                         valid;
   logic                         ready;
   logic [erc_pkg::CMD_W-1:0]    command;
   logic [erc_pkg::FLOOR_W-1:0]  button_floor;
   logic [erc_pkg::FLOOR_W-1:0]  cabin_floor;
   logic                         going_down;

   modport source (output valid, command, button_floor, cabin_floor, going_down,
                   input ready);
   modport sink   (input valid, command, button_floor, cabin_floor, going_down,
                   output ready);
endinterface

interface erc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [erc_pkg::ACT_W-1:0]    action;
   logic [erc_pkg::FLOOR_W-1:0]  target_floor;
   logic [erc_pkg::MODE_W-1:0]   mode_now;

   modport source (output valid, action, target_floor, mode_now, input ready);
   modport sink   (input valid, action, target_floor, mode_now, output ready);
endinterface

>>> rtl/erc_scan.sv
// ----------------------------------------------------------------------------
// erc_scan
// floor-by-floor target search, one floor per cycle through one compare unit
// ----------------------------------------------------------------------------
module erc_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  erc_pkg::scan_ctl_type               ctl,
   input  logic [erc_pkg::FLOOR_COUNT-1:0]     bits,
   output erc_pkg::scan_res_type               res
);

   logic                               busy_ff,  busy_in;
   logic [erc_pkg::FLOOR_W-1:0]        floor_ff, floor_in;
   logic [erc_pkg::FLOOR_COUNT-1:0]    bits_ff,  bits_in;
   logic [erc_pkg::FLOOR_W-1:0]        cabin_ff, cabin_in;
   logic                               down_ff,  down_in;
   logic [erc_pkg::FLOOR_W-1:0]        low_ff,   low_in;
   logic [erc_pkg::FLOOR_W-1:0]        high_ff,  high_in;
   logic                               done_ff,  done_in;
   logic [erc_pkg::FLOOR_W-1:0]        target_ff, target_in;
   logic [erc_pkg::FLOOR_W-1:0]        low_nx, high_nx;
   logic                               last;

   always_comb begin
      low_nx  = low_ff;
      high_nx = high_ff;
      if (bits_ff[0]) begin
         if (floor_ff >= cabin_ff && low_ff == '0) begin
            low_nx = floor_ff;
         end
         if (floor_ff <= cabin_ff) begin
            high_nx = floor_ff;
         end
      end
      last = (floor_ff == erc_pkg::FLOOR_W'(erc_pkg::FLOOR_COUNT));
   end

   always_comb begin
      busy_in   = busy_ff;
      floor_in  = floor_ff;
      bits_in   = bits_ff;
      cabin_in  = cabin_ff;
      down_in   = down_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      done_in   = 1'b0;
      target_in = target_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         floor_in = erc_pkg::FLOOR_W'(1);
         bits_in  = bits;
         cabin_in = ctl.cabin;
         down_in  = ctl.down;
         low_in   = '0;
         high_in  = '0;
      end else if (busy_ff) begin
         floor_in = floor_ff + erc_pkg::FLOOR_W'(1);
         bits_in  = bits_ff >> 1;
         low_in   = low_nx;
         high_in  = high_nx;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (down_ff) begin
               target_in = (high_nx != '0) ? high_nx : low_nx;
            end else begin
               target_in = (low_nx != '0) ? low_nx : high_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      floor_ff  <= floor_in;
      bits_ff   <= bits_in;
      cabin_ff  <= cabin_in;
      down_ff   <= down_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      target_ff <= target_in;
   end

   assign res.done   = done_ff;
   assign res.target = target_ff;

endmodule

>>> rtl/elevator_request_controller_top.sv
// ----------------------------------------------------------------------------
// elevator_request_controller_top
// elevator controller: request bitmap, door-wait counter and mode sequencer
// ----------------------------------------------------------------------------
// timing: a response is registered and appears in the cycle after the beat that
//   produced it; a decide report that needs a target search passes the scan
//   unit, which visits one floor per cycle, its done register and the response register
// throughput: one beat per cycle while the response is not stalled, none while a search runs
// reset: mode idle, no requests, wait count zero, wait_ticks 2000
// ----------------------------------------------------------------------------
module elevator_request_controller_top (
   input  logic                        clock,
   input  logic                        reset,
   erc_req_if.sink                     req_if,
   erc_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [erc_pkg::TICK_W-1:0]  csr_wr_data
);

   typedef enum logic {
      ST_READY,
      ST_SCAN
   } state_type;

   state_type                          state_ff,   state_in;
   erc_pkg::mode_type                  mode_ff,    mode_in;
   logic [erc_pkg::FLOOR_COUNT-1:0]    bits_ff,    bits_in;
   logic [erc_pkg::TICK_W-1:0]         wcount_ff,  wcount_in;
   logic [erc_pkg::TICK_W-1:0]         wticks_ff,  wticks_in;
   logic                               rvalid_ff,  rvalid_in;
   erc_pkg::act_type                   ract_ff,    ract_in;
   logic [erc_pkg::FLOOR_W-1:0]        rtarget_ff, rtarget_in;
   erc_pkg::mode_type                  rmode_ff,   rmode_in;

   erc_pkg::scan_ctl_type              scan_ctl;
   erc_pkg::scan_res_type              scan_res;

   logic                               accept;
   logic                               out_free;
   logic                               btn_ok, cab_ok;
   logic [erc_pkg::FLOOR_W-1:0]        btn_m1, cab_m1;
   logic [erc_pkg::FLOOR_IDX_W-1:0]    btn_idx, cab_idx;
   logic                               cab_req;
   logic                               can_open;
   logic [erc_pkg::TICK_W-1:0]         wcount_inc;

   erc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .bits  (bits_ff),
      .res   (scan_res)
   );

   assign out_free      = !rvalid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_READY) && out_free;
   assign accept        = req_if.valid && req_if.ready;

   assign btn_ok  = (req_if.button_floor != '0) &&
                    (req_if.button_floor <= erc_pkg::FLOOR_W'(erc_pkg::FLOOR_COUNT));
   assign cab_ok  = (req_if.cabin_floor != '0) &&
                    (req_if.cabin_floor <= erc_pkg::FLOOR_W'(erc_pkg::FLOOR_COUNT));
   assign btn_m1  = req_if.button_floor - erc_pkg::FLOOR_W'(1);
   assign cab_m1  = req_if.cabin_floor - erc_pkg::FLOOR_W'(1);
   assign btn_idx = btn_m1[erc_pkg::FLOOR_IDX_W-1:0];
   assign cab_idx = cab_m1[erc_pkg::FLOOR_IDX_W-1:0];
   assign cab_req = cab_ok && bits_ff[cab_idx];
   assign can_open = (mode_ff == erc_pkg::MODE_DECIDING) ||
                     (mode_ff == erc_pkg::MODE_CLOSING)  ||
                     (mode_ff == erc_pkg::MODE_WAITING)  ||
                     (mode_ff == erc_pkg::MODE_IDLE);
   assign wcount_inc = (wcount_ff < erc_pkg::TICK_MAX) ?
                       wcount_ff + erc_pkg::TICK_W'(1) : wcount_ff;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      bits_in        = bits_ff;
      wcount_in      = wcount_ff;
      wticks_in      = csr_wr_en ? csr_wr_data : wticks_ff;
      rvalid_in      = rvalid_ff && !rsp_if.ready;
      ract_in        = ract_ff;
      rtarget_in     = rtarget_ff;
      rmode_in       = rmode_ff;
      scan_ctl.start = 1'b0;
      scan_ctl.cabin = req_if.cabin_floor;
      scan_ctl.down  = req_if.going_down;

      unique case (state_ff)
         ST_READY: begin
            if (accept) begin
               unique case (req_if.command)
                  erc_pkg::CMD_BUTTON: begin
                     if (btn_ok) begin
                        bits_in[btn_idx] = 1'b1;
                        if (mode_ff == erc_pkg::MODE_IDLE ||
                            (mode_ff == erc_pkg::MODE_CLOSING &&
                             req_if.button_floor == req_if.cabin_floor)) begin
                           mode_in    = erc_pkg::MODE_OPENING;
                           rvalid_in  = 1'b1;
                           ract_in    = erc_pkg::ACT_OPEN;
                           rtarget_in = '0;
                           rmode_in   = erc_pkg::MODE_OPENING;
                        end else if (req_if.button_floor == req_if.cabin_floor) begin
                           bits_in[btn_idx] = 1'b0;
                           rvalid_in  = 1'b1;
                           ract_in    = erc_pkg::ACT_RELEASE;
                           rtarget_in = req_if.button_floor;
                           rmode_in   = mode_ff;
                        end
                     end
                  end
                  erc_pkg::CMD_OPEN: begin
                     if (mode_ff == erc_pkg::MODE_CLOSING ||
                         mode_ff == erc_pkg::MODE_IDLE) begin
                        mode_in    = erc_pkg::MODE_OPENING;
                        rvalid_in  = 1'b1;
                        ract_in    = erc_pkg::ACT_OPEN;
                        rtarget_in = '0;
                        rmode_in   = erc_pkg::MODE_OPENING;
                     end
                  end
                  erc_pkg::CMD_OPENED: begin
                     if (mode_ff == erc_pkg::MODE_OPENING) begin
                        mode_in   = erc_pkg::MODE_WAITING;
                        wcount_in = '0;
                        if (cab_ok) begin
                           bits_in[cab_idx] = 1'b0;
                        end
                        rvalid_in  = 1'b1;
                        ract_in    = erc_pkg::ACT_RELEASE;
                        rtarget_in = req_if.cabin_floor;
                        rmode_in   = erc_pkg::MODE_WAITING;
                     end
                  end
                  erc_pkg::CMD_DECIDE: begin
                     if (mode_ff == erc_pkg::MODE_MOVING ||
                         mode_ff == erc_pkg::MODE_CLOSING) begin
                        mode_in = erc_pkg::MODE_DECIDING;
                        if (cab_req) begin
                           rvalid_in  = 1'b1;
                           ract_in    = erc_pkg::ACT_STOP;
                           rtarget_in = '0;
                           rmode_in   = erc_pkg::MODE_DECIDING;
                        end else begin
                           scan_ctl.start = 1'b1;
                           state_in       = ST_SCAN;
                        end
                     end
                  end
                  erc_pkg::CMD_STOPPED: begin
                     if (can_open) begin
                        mode_in    = erc_pkg::MODE_OPENING;
                        rvalid_in  = 1'b1;
                        ract_in    = erc_pkg::ACT_OPEN;
                        rtarget_in = '0;
                        rmode_in   = erc_pkg::MODE_OPENING;
                     end
                  end
                  erc_pkg::CMD_TICK: begin
                     if (mode_ff == erc_pkg::MODE_WAITING) begin
                        if (wcount_inc >= wticks_ff) begin
                           wcount_in  = '0;
                           mode_in    = erc_pkg::MODE_CLOSING;
                           rvalid_in  = 1'b1;
                           ract_in    = erc_pkg::ACT_CLOSE;
                           rtarget_in = '0;
                           rmode_in   = erc_pkg::MODE_CLOSING;
                        end else begin
                           wcount_in = wcount_inc;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               state_in = ST_READY;
               if (scan_res.target != '0) begin
                  mode_in    = erc_pkg::MODE_MOVING;
                  rvalid_in  = 1'b1;
                  ract_in    = erc_pkg::ACT_MOVE;
                  rtarget_in = scan_res.target;
                  rmode_in   = erc_pkg::MODE_MOVING;
               end else begin
                  mode_in = erc_pkg::MODE_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_READY;
         mode_ff   <= erc_pkg::MODE_IDLE;
         bits_ff   <= '0;
         wcount_ff <= '0;
         wticks_ff <= erc_pkg::WAIT_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         bits_ff   <= bits_in;
         wcount_ff <= wcount_in;
         wticks_ff <= wticks_in;
         rvalid_ff <= rvalid_in;
      end
      ract_ff    <= ract_in;
      rtarget_ff <= rtarget_in;
      rmode_ff   <= rmode_in;
   end

   assign rsp_if.valid        = rvalid_ff;
   assign rsp_if.action       = ract_ff;
   assign rsp_if.target_floor = rtarget_ff;
   assign rsp_if.mode_now     = rmode_ff;

endmodule
